// ===== rtl/core/sde_pkg.sv =====
// ----------------------------------------------------------------------------
// sde_pkg
// Shared types and character constants for the SMTP dot-stuffing encoder.
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOM  = 1'b1;

  typedef struct packed {
    logic                          at_line_start;
    logic                          cr_just_seen;
  } line_state_t;

  // bytes[0] goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0]      bytes;
    logic [CntW-1:0]               cnt;
    logic                          eom;
  } burst_t;

endpackage

// ===== rtl/core/sde_expand.sv =====
// ----------------------------------------------------------------------------
// sde_expand
// Expands one input transaction into its burst of encoded bytes and the
// next line state.
// ----------------------------------------------------------------------------
module sde_expand
  import sde_pkg::*;
(
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  line_state_t st,
  output burst_t      burst,
  output line_state_t st_nxt
);

  always_comb begin
    burst  = '0;
    st_nxt = st;
    if (mode == MODE_EOM) begin
      burst.eom = 1'b1;
      if (!st.at_line_start) begin
        burst.bytes[0] = CH_CR;
        burst.bytes[1] = CH_LF;
        burst.bytes[2] = CH_DOT;
        burst.bytes[3] = CH_CR;
        burst.bytes[4] = CH_LF;
        burst.cnt      = CntW'(5);
      end else begin
        burst.bytes[0] = CH_DOT;
        burst.bytes[1] = CH_CR;
        burst.bytes[2] = CH_LF;
        burst.cnt      = CntW'(3);
      end
      st_nxt.at_line_start = 1'b1;
      st_nxt.cr_just_seen  = 1'b0;
    end else if (data_byte == CH_LF && st.cr_just_seen) begin
      st_nxt.cr_just_seen = 1'b0;
    end else if (data_byte == CH_CR || data_byte == CH_LF) begin
      burst.bytes[0]       = CH_CR;
      burst.bytes[1]       = CH_LF;
      burst.cnt            = CntW'(2);
      st_nxt.at_line_start = 1'b1;
      st_nxt.cr_just_seen  = (data_byte == CH_CR);
    end else begin
      if (st.at_line_start && data_byte == CH_DOT) begin
        burst.bytes[0] = CH_DOT;
        burst.bytes[1] = CH_DOT;
        burst.cnt      = CntW'(2);
      end else begin
        burst.bytes[0] = data_byte;
        burst.cnt      = CntW'(1);
      end
      st_nxt.at_line_start = 1'b0;
      st_nxt.cr_just_seen  = 1'b0;
    end
  end

endmodule

// ===== rtl/core/smtp_dot_stuffing_encoder.sv =====
// ----------------------------------------------------------------------------
// smtp_dot_stuffing_encoder
// Each input passes the hold register, then the output burst register.
// Throughput, while out_tready is high: one input per cycle while each yields
// at most one byte, as the output burst register, emitting one byte a cycle,
// sets the rate; an input yielding n bytes holds it until all n are taken.
// Reset (rst_n low, synchronous) empties both stages, sets start-of-line.
// ----------------------------------------------------------------------------
module smtp_dot_stuffing_encoder
  import sde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // [0] message_done
);

  logic        hold_v_r, hold_v_nxt;
  logic        hold_mode_r;
  logic [7:0]  hold_byte_r;
  line_state_t st_r, st_nxt, st_exp;
  burst_t      exp_burst;
  logic [MaxBytes-1:0][7:0] bytes_r, bytes_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic        eom_r, eom_nxt;
  logic        take, burst_free, move, accept;

  sde_expand u_expand (
    .mode      (hold_mode_r),
    .data_byte (hold_byte_r),
    .st        (st_r),
    .burst     (exp_burst),
    .st_nxt    (st_exp)
  );

  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = (rem_r == CntW'(1));
  assign out_tuser  = eom_r && (rem_r == CntW'(1));

  assign take       = out_tvalid && out_tready;
  assign burst_free = (rem_r == '0) || (take && rem_r == CntW'(1));
  assign move       = hold_v_r && burst_free;
  assign in_tready  = !hold_v_r || burst_free;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (accept) begin
      hold_v_nxt = 1'b1;
    end else if (move) begin
      hold_v_nxt = 1'b0;
    end
    st_nxt    = move ? st_exp : st_r;
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    eom_nxt   = eom_r;
    if (move) begin
      bytes_nxt = exp_burst.bytes;
      rem_nxt   = exp_burst.cnt;
      eom_nxt   = exp_burst.eom;
    end else if (take) begin
      bytes_nxt = {8'h00, bytes_r[MaxBytes-1:1]};
      rem_nxt   = rem_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r         <= 1'b0;
      rem_r            <= '0;
      st_r.at_line_start <= 1'b1;
      st_r.cr_just_seen  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      rem_r    <= rem_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_mode_r <= in_tuser;
      hold_byte_r <= in_tdata;
    end
    bytes_r <= bytes_nxt;
    eom_r   <= eom_nxt;
  end

endmodule

// ===== rtl/core/sde_checker.sv =====
// ----------------------------------------------------------------------------
// sde_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module sde_checker
  import sde_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("message_done without tlast");

  a_done_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == CH_LF)
    else $error("message_done on a byte other than LF");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

endmodule

bind smtp_dot_stuffing_encoder sde_checker u_sde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
